### design/gnl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_pkg: shared definitions for the gate netlist levelizer
// Store sizes, field widths, payload structs and the wire id range check.
// ----------------------------------------------------------------------------
package gnl_pkg;

    localparam int WIRE_COUNT   = 65536;
    localparam int LAYER_LIMIT  = 4096;
    localparam int COUNT_BITS   = 20;

    localparam int WIRE_ID_W    = 16;
    localparam int LAYER_W      = 12;
    localparam int POP_W        = 20;

    localparam int WIRE_ADDR_W  = $clog2(WIRE_COUNT);
    localparam int DEPTH_W      = $clog2(LAYER_LIMIT);
    localparam int CLEAR_COUNT  = (WIRE_COUNT > LAYER_LIMIT) ? WIRE_COUNT : LAYER_LIMIT;
    localparam int CLEAR_W      = $clog2(CLEAR_COUNT);

    typedef logic [WIRE_ID_W-1:0]  wire_id_t;
    typedef logic [DEPTH_W-1:0]    depth_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CLEAR_W-1:0]    clr_ptr_t;

    localparam depth_t   LAYER_TOP = depth_t'(LAYER_LIMIT - 1);
    localparam count_t   COUNT_TOP = '1;
    localparam clr_ptr_t CLEAR_END = clr_ptr_t'(CLEAR_COUNT - 1);

    typedef struct packed {
        wire_id_t left_wire;
        wire_id_t right_wire;
        wire_id_t out_wire;
        logic     last_gate;
    } gate_t;

    typedef struct packed {
        logic [LAYER_W-1:0] assigned_layer;
        logic [LAYER_W-1:0] deepest_layer;
        logic [POP_W-1:0]   layer_population;
        logic               layer_overflow;
    } res_t;

    function automatic logic wire_in_range(input wire_id_t id);
        return 32'(id) < 32'(WIRE_COUNT);
    endfunction

endpackage

`default_nettype wire

### design/gnl_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_channels: valid/ready channels of the levelizer
// One channel carries gate words in, the other carries result words out.
// ----------------------------------------------------------------------------
interface gnl_gate_if;
    logic                     valid;
    logic                     ready;
    logic [gnl_pkg::WIRE_ID_W-1:0] left_wire;
    logic [gnl_pkg::WIRE_ID_W-1:0] right_wire;
    logic [gnl_pkg::WIRE_ID_W-1:0] out_wire;
    logic                     last_gate;

    modport source (output valid, left_wire, right_wire, out_wire, last_gate,
                    input ready);
    modport sink   (input valid, left_wire, right_wire, out_wire, last_gate,
                    output ready);
endinterface

interface gnl_result_if;
    logic                        valid;
    logic                        ready;
    logic [gnl_pkg::LAYER_W-1:0] assigned_layer;
    logic [gnl_pkg::LAYER_W-1:0] deepest_layer;
    logic [gnl_pkg::POP_W-1:0]   layer_population;
    logic                        layer_overflow;

    modport source (output valid, assigned_layer, deepest_layer, layer_population,
                    layer_overflow, input ready);
    modport sink   (input valid, assigned_layer, deepest_layer, layer_population,
                    layer_overflow, output ready);
endinterface

`default_nettype wire

### design/gate_netlist_levelizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gate_netlist_levelizer: as-soon-as-possible levelization of a gate netlist
// Assigns each two-input gate a layer one above its deepest input wire, saturating at the top layer.
// ----------------------------------------------------------------------------
// Each gate word passes these steps from acceptance to a result in the output
// register: the two input wire layers are read from the wire store, the layer
// is formed and its histogram entry read, both stores are written, and the
// result moves to the output register, which lets the next gate word in while a
// result waits. After reset, and after every gate word marked last, a
// clearing sweep writes zero to the wire store and the histogram one entry a
// cycle; it runs over every wire store address, and no gate word is
// accepted during it. Wires not driven earlier in a netlist read as layer 0.
// ----------------------------------------------------------------------------
module gate_netlist_levelizer
    import gnl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gnl_gate_if.sink    gate,
    gnl_result_if.source result
);

    gate_t                  in_gate;
    logic                   wire_we;
    logic [WIRE_ADDR_W-1:0] wire_waddr;
    depth_t                 wire_wdata;
    logic [WIRE_ADDR_W-1:0] wire_raddr_a;
    logic [WIRE_ADDR_W-1:0] wire_raddr_b;
    depth_t                 wire_rdata_a;
    depth_t                 wire_rdata_b;
    logic                   hist_we;
    depth_t                 hist_waddr;
    count_t                 hist_wdata;
    depth_t                 hist_raddr;
    count_t                 hist_rdata;
    logic                   res_valid;
    logic                   res_ready;
    res_t                   res;
    res_t                   out_res;

    assign in_gate.left_wire  = gate.left_wire;
    assign in_gate.right_wire = gate.right_wire;
    assign in_gate.out_wire   = gate.out_wire;
    assign in_gate.last_gate  = gate.last_gate;

    gnl_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (gate.valid),
        .in_ready     (gate.ready),
        .in_gate      (in_gate),
        .wire_we      (wire_we),
        .wire_waddr   (wire_waddr),
        .wire_wdata   (wire_wdata),
        .wire_raddr_a (wire_raddr_a),
        .wire_raddr_b (wire_raddr_b),
        .wire_rdata_a (wire_rdata_a),
        .wire_rdata_b (wire_rdata_b),
        .hist_we      (hist_we),
        .hist_waddr   (hist_waddr),
        .hist_wdata   (hist_wdata),
        .hist_raddr   (hist_raddr),
        .hist_rdata   (hist_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    gnl_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (WIRE_COUNT)
    ) u_wire_store (
        .clk     (clk),
        .we      (wire_we),
        .waddr   (wire_waddr),
        .wdata   (wire_wdata),
        .raddr_a (wire_raddr_a),
        .rdata_a (wire_rdata_a),
        .raddr_b (wire_raddr_b),
        .rdata_b (wire_rdata_b)
    );

    gnl_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (LAYER_LIMIT)
    ) u_histogram (
        .clk     (clk),
        .we      (hist_we),
        .waddr   (hist_waddr),
        .wdata   (hist_wdata),
        .raddr_a (hist_raddr),
        .rdata_a (hist_rdata),
        .raddr_b (hist_raddr),
        .rdata_b ()
    );

    gnl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.assigned_layer   = out_res.assigned_layer;
    assign result.deepest_layer    = out_res.deepest_layer;
    assign result.layer_population = out_res.layer_population;
    assign result.layer_overflow   = out_res.layer_overflow;

endmodule

`default_nettype wire

### design/gnl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module gnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### design/gnl_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_seq: levelizing sequencer
// Reads the input wire layers, forms the gate layer, updates the histogram
// and wire store, and sweeps both stores clear after reset and a last gate.
// ----------------------------------------------------------------------------
module gnl_seq
    import gnl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire gate_t                  in_gate,
    output logic                        wire_we,
    output logic [WIRE_ADDR_W-1:0]      wire_waddr,
    output depth_t                      wire_wdata,
    output logic [WIRE_ADDR_W-1:0]      wire_raddr_a,
    output logic [WIRE_ADDR_W-1:0]      wire_raddr_b,
    input  wire depth_t                 wire_rdata_a,
    input  wire depth_t                 wire_rdata_b,
    output logic                        hist_we,
    output depth_t                      hist_waddr,
    output count_t                      hist_wdata,
    output depth_t                      hist_raddr,
    input  wire count_t                 hist_rdata,
    output logic                        res_valid,
    input  wire logic                   res_ready,
    output res_t                        res
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIRE,
        ST_HIST
    } state_t;

    state_t   state_reg, state_next;
    clr_ptr_t clr_ptr_reg, clr_ptr_next;
    gate_t    gate_reg, gate_next;
    logic     lin_reg, lin_next;
    logic     rin_reg, rin_next;
    depth_t   layer_reg, layer_next;
    logic     ovf_reg, ovf_next;
    depth_t   max_reg, max_next;
    logic     pend_reg, pend_next;
    res_t     res_reg, res_next;

    depth_t             left_d;
    depth_t             right_d;
    depth_t             deeper;
    logic [DEPTH_W:0]   sum;
    logic               sat;
    depth_t             layer_c;
    count_t             cnt;
    depth_t             new_max;
    logic               accept;

    assign in_ready  = (state_reg == ST_IDLE) && !pend_reg;
    assign accept    = in_valid && in_ready;
    assign res_valid = pend_reg;
    assign res       = res_reg;

    assign wire_raddr_a = WIRE_ADDR_W'(in_gate.left_wire);
    assign wire_raddr_b = WIRE_ADDR_W'(in_gate.right_wire);

    assign left_d  = lin_reg ? wire_rdata_a : '0;
    assign right_d = rin_reg ? wire_rdata_b : '0;
    assign deeper  = (left_d > right_d) ? left_d : right_d;
    assign sum     = {1'b0, deeper} + (DEPTH_W + 1)'(1);
    assign sat     = sum > {1'b0, LAYER_TOP};
    assign layer_c = sat ? LAYER_TOP : sum[DEPTH_W-1:0];
    assign hist_raddr = layer_c;

    assign cnt     = (hist_rdata == COUNT_TOP) ? COUNT_TOP : hist_rdata + count_t'(1);
    assign new_max = (layer_reg > max_reg) ? layer_reg : max_reg;

    always_comb
    begin
        wire_we    = 1'b0;
        wire_waddr = WIRE_ADDR_W'(clr_ptr_reg);
        wire_wdata = '0;
        hist_we    = 1'b0;
        hist_waddr = depth_t'(clr_ptr_reg);
        hist_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wire_we = 32'(clr_ptr_reg) < 32'(WIRE_COUNT);
                hist_we = 32'(clr_ptr_reg) < 32'(LAYER_LIMIT);
            end
            ST_HIST:
            begin
                wire_we    = wire_in_range(gate_reg.out_wire);
                wire_waddr = WIRE_ADDR_W'(gate_reg.out_wire);
                wire_wdata = layer_reg;
                hist_we    = 1'b1;
                hist_waddr = layer_reg;
                hist_wdata = cnt;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        gate_next    = gate_reg;
        lin_next     = lin_reg;
        rin_next     = rin_reg;
        layer_next   = layer_reg;
        ovf_next     = ovf_reg;
        max_next     = max_reg;
        pend_next    = pend_reg && !res_ready;
        res_next     = res_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + clr_ptr_t'(1);
                if (clr_ptr_reg == CLEAR_END)
                begin
                    clr_ptr_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    gate_next  = in_gate;
                    lin_next   = wire_in_range(in_gate.left_wire);
                    rin_next   = wire_in_range(in_gate.right_wire);
                    state_next = ST_WIRE;
                end
            end
            ST_WIRE:
            begin
                layer_next = layer_c;
                ovf_next   = sat;
                state_next = ST_HIST;
            end
            ST_HIST:
            begin
                res_next.assigned_layer   = LAYER_W'(layer_reg);
                res_next.deepest_layer    = LAYER_W'(new_max);
                res_next.layer_population = POP_W'(cnt);
                res_next.layer_overflow   = ovf_reg;
                pend_next                 = 1'b1;
                if (gate_reg.last_gate)
                begin
                    max_next   = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    max_next   = new_max;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            max_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            max_reg     <= max_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gate_reg  <= gate_next;
        lin_reg   <= lin_next;
        rin_reg   <= rin_next;
        layer_reg <= layer_next;
        ovf_reg   <= ovf_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

### design/gnl_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_out_stage: result output register
// Holds one result word for the downstream side and frees the sequencer.
// ----------------------------------------------------------------------------
module gnl_out_stage
    import gnl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_valid,
    output logic      res_ready,
    input  wire res_t res,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic valid_reg, valid_next;
    res_t data_reg, data_next;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

### design/gnl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnl_checker: port-level checks for the levelizer
// Watches the gate and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module gnl_checker
    import gnl_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [LAYER_W-1:0] assigned_layer,
    input wire logic [LAYER_W-1:0] deepest_layer,
    input wire logic               layer_overflow
);

    localparam logic [LAYER_W-1:0] OUT_TOP = LAYER_W'(LAYER_LIMIT - 1);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("gate word accepted while previous one in flight");

    a_layer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> assigned_layer != '0)
        else $error("result word with layer zero");

    a_overflow_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && layer_overflow |-> assigned_layer == OUT_TOP)
        else $error("overflow flagged below the top layer");

    a_deepest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> deepest_layer >= assigned_layer)
        else $error("deepest layer below gate layer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(assigned_layer))
        else $error("stalled result word changed");

endmodule

bind gate_netlist_levelizer gnl_checker u_gnl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (gate.valid),
    .in_ready       (gate.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .assigned_layer (result.assigned_layer),
    .deepest_layer  (result.deepest_layer),
    .layer_overflow (result.layer_overflow)
);

`default_nettype wire

### dv/tb_gate_netlist_levelizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gate_netlist_levelizer: self-checking bench for the netlist levelizer
// Streams directed and random gate words through the levelizer, including a
// long dependence chain that builds deep layers, and compares every result
// word field by field with a layer predictor kept in a small scoreboard
// class. Both channels idle at random; a watchdog ends a run that stalls.
// ----------------------------------------------------------------------------
module tb_gate_netlist_levelizer;
    import gnl_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int IDLE_PERCENT    = 6;
    localparam int CHAIN_LEN       = 600;

    class levelizer_scoreboard;
        depth_t wire_layer[int];
        longint layer_count[int];
        depth_t deepest = '0;
        res_t   layer_reports[$];
        int     errors;

        function void levelize_gate(gate_t g);
            int     left_depth;
            int     right_depth;
            int     layer;
            longint cnt;
            res_t   r;
            left_depth  = (int'(g.left_wire) < WIRE_COUNT && wire_layer.exists(g.left_wire))
                          ? int'(wire_layer[g.left_wire]) : 0;
            right_depth = (int'(g.right_wire) < WIRE_COUNT && wire_layer.exists(g.right_wire))
                          ? int'(wire_layer[g.right_wire]) : 0;
            layer = ((left_depth > right_depth) ? left_depth : right_depth) + 1;
            r.layer_overflow = 1'b0;
            if (layer > LAYER_LIMIT - 1)
            begin
                layer = LAYER_LIMIT - 1;
                r.layer_overflow = 1'b1;
            end
            if (int'(g.out_wire) < WIRE_COUNT)
                wire_layer[g.out_wire] = depth_t'(layer);
            cnt = (layer_count.exists(layer) ? layer_count[layer] : 0) + 1;
            if (cnt > (longint'(1) << COUNT_BITS) - 1)
                cnt = (longint'(1) << COUNT_BITS) - 1;
            layer_count[layer] = cnt;
            if (depth_t'(layer) > deepest)
                deepest = depth_t'(layer);
            r.assigned_layer   = LAYER_W'(layer);
            r.deepest_layer    = LAYER_W'(deepest);
            r.layer_population = POP_W'(cnt);
            layer_reports.push_back(r);
            if (g.last_gate)
            begin
                wire_layer.delete();
                layer_count.delete();
                deepest = '0;
            end
        endfunction

        function void compare_report(res_t got);
            res_t want;
            if (layer_reports.size() == 0)
            begin
                $display("%0t: unexpected result word: layer %0d deepest %0d pop %0d ovf %0b",
                         $time, got.assigned_layer, got.deepest_layer,
                         got.layer_population, got.layer_overflow);
                errors++;
                return;
            end
            want = layer_reports.pop_front();
            if (got.assigned_layer !== want.assigned_layer)
            begin
                $display("%0t: assigned_layer expected %0d actual %0d",
                         $time, want.assigned_layer, got.assigned_layer);
                errors++;
            end
            if (got.deepest_layer !== want.deepest_layer)
            begin
                $display("%0t: deepest_layer expected %0d actual %0d",
                         $time, want.deepest_layer, got.deepest_layer);
                errors++;
            end
            if (got.layer_population !== want.layer_population)
            begin
                $display("%0t: layer_population expected %0d actual %0d",
                         $time, want.layer_population, got.layer_population);
                errors++;
            end
            if (got.layer_overflow !== want.layer_overflow)
            begin
                $display("%0t: layer_overflow expected %0b actual %0b",
                         $time, want.layer_overflow, got.layer_overflow);
                errors++;
            end
        endfunction

        function int waiting();
            return layer_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   stall_cycles;

    levelizer_scoreboard sb = new;

    gnl_gate_if   gate_ch ();
    gnl_result_if res_ch ();

    gate_netlist_levelizer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .gate   (gate_ch),
        .result (res_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (gate_ch.valid && gate_ch.ready)
                sb.levelize_gate(gate_t'{gate_ch.left_wire, gate_ch.right_wire,
                                         gate_ch.out_wire, gate_ch.last_gate});
            if (res_ch.valid && res_ch.ready)
                sb.compare_report(res_t'{res_ch.assigned_layer, res_ch.deepest_layer,
                                         res_ch.layer_population, res_ch.layer_overflow});
        end
        if ((gate_ch.valid && gate_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        $display("gate_netlist_levelizer verification failed");
        $finish;
    end

    task automatic send_gate(input wire_id_t lw, input wire_id_t rw, input wire_id_t ow,
                             input logic last);
        gate_ch.valid      <= 1'b1;
        gate_ch.left_wire  <= lw;
        gate_ch.right_wire <= rw;
        gate_ch.out_wire   <= ow;
        gate_ch.last_gate  <= last;
        @(posedge clk);
        while (!gate_ch.ready)
            @(posedge clk);
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gate_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        gate_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        wire_id_t base;
        wire_id_t lw;
        wire_id_t rw;
        wire_id_t ow;
        wire_id_t recent[$];
        int       len;
        int       mode;

        rst_n              = 1'b0;
        calm               = 1'b0;
        gate_ch.valid      = 1'b0;
        gate_ch.left_wire  = '0;
        gate_ch.right_wire = '0;
        gate_ch.out_wire   = '0;
        gate_ch.last_gate  = 1'b0;
        res_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, same wire in and out, back-to-back dependences, last gate
        send_gate(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_gate(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_gate(16'h0000, 16'h1234, 16'hAAAA, 1'b0);
        send_gate(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        send_gate(16'hAAAA, 16'h5555, 16'h0001, 1'b0);
        drain_results();
        send_gate(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        send_gate(16'h0001, 16'h0001, 16'h0001, 1'b0);
        send_gate(16'h0001, 16'hFFFF, 16'h7FFF, 1'b0);
        send_gate(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
        send_gate(16'h7FFF, 16'h0001, 16'hFFFF, 1'b1);
        send_gate(16'hFFFF, 16'hAAAA, 16'h0002, 1'b0);
        send_gate(16'h0002, 16'h0002, 16'h0003, 1'b0);
        send_gate(16'h0003, 16'h0000, 16'h0000, 1'b1);

        // random netlists: mostly gates fed from recent outputs
        for (int n = 0; n < 5; n++)
        begin
            calm = (n == 2);
            base = wire_id_t'($urandom);
            len  = $urandom_range(200, 370);
            recent.delete();
            for (int k = 0; k < len; k++)
            begin
                mode = $urandom_range(0, 99);
                if (mode < 80)
                begin
                    lw = (recent.size() != 0 && $urandom_range(0, 3) != 0)
                         ? recent[$urandom_range(0, recent.size() - 1)]
                         : base + wire_id_t'($urandom_range(0, 255));
                    rw = (recent.size() != 0 && $urandom_range(0, 3) != 0)
                         ? recent[$urandom_range(0, recent.size() - 1)]
                         : base + wire_id_t'($urandom_range(0, 255));
                    ow = base + wire_id_t'($urandom_range(0, 255));
                end
                else if (mode < 90)
                begin
                    lw = wire_id_t'($urandom);
                    rw = wire_id_t'($urandom);
                    ow = wire_id_t'($urandom);
                end
                else
                begin
                    lw = (recent.size() != 0) ? recent[$urandom_range(0, recent.size() - 1)]
                                              : wire_id_t'($urandom);
                    rw = base + wire_id_t'($urandom_range(0, 255));
                    ow = lw;
                end
                send_gate(lw, rw, ow, k == len - 1);
                recent.push_back(ow);
                if (recent.size() > 12)
                    void'(recent.pop_front());
                if (n == 1 && k == 100)
                    drain_results();
            end
        end
        calm = 1'b0;

        // long dependence chain
        for (int i = 0; i < CHAIN_LEN; i++)
        begin
            if (i % 2 == 0)
                send_gate(wire_id_t'(i), wire_id_t'($urandom), wire_id_t'(i + 1),
                          i == CHAIN_LEN - 1);
            else
                send_gate(wire_id_t'($urandom), wire_id_t'(i), wire_id_t'(i + 1),
                          i == CHAIN_LEN - 1);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("gate_netlist_levelizer verification clean");
        else
            $display("gate_netlist_levelizer verification failed");
        $finish;
    end

endmodule
